// File: sv/crc24fc_pkg.sv
// ----------------------------------------------------------------------------
// CRC-24 frame checker package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package crc24fc_pkg;

    localparam int CrcWidth  = 24;
    localparam int DataWidth = 8;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 24;

    localparam logic [CfgIdxW-1:0] CFG_INIT_VALUE = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_POLY_TAPS  = 8'd1;

    localparam logic [CrcWidth-1:0] INIT_RESET = 24'h777777;
    localparam logic [CrcWidth-1:0] TAPS_RESET = 24'h800463;

    typedef struct packed {
        logic [CrcWidth-1:0] init_value;
        logic [CrcWidth-1:0] poly_taps;
    } cfg_t;

    typedef struct packed {
        logic stg_valid;
        logic advance;
    } core_stat_t;

endpackage

// File: sv/crc24fc_cfg.sv
// ----------------------------------------------------------------------------
// CRC-24 frame checker configuration registers
// Holds the initial value and the tap pattern; writes to other indexes drop.
// ----------------------------------------------------------------------------
module crc24fc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crc24fc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [crc24fc_pkg::CfgDataW-1:0]  cfg_data,
    output crc24fc_pkg::cfg_t                 cfg
);

    logic [crc24fc_pkg::CrcWidth-1:0] init_reg;
    logic [crc24fc_pkg::CrcWidth-1:0] taps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= crc24fc_pkg::INIT_RESET;
            taps_reg <= crc24fc_pkg::TAPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crc24fc_pkg::CFG_INIT_VALUE: init_reg <= cfg_data;
                crc24fc_pkg::CFG_POLY_TAPS:  taps_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign cfg.init_value = init_reg;
    assign cfg.poly_taps  = taps_reg;

endmodule

// File: sv/crc24fc_core.sv
// ----------------------------------------------------------------------------
// CRC-24 frame checker datapath
// Input register, eight-bit division step, remainder and result register.
// ----------------------------------------------------------------------------
module crc24fc_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  crc24fc_pkg::cfg_t                  cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [crc24fc_pkg::DataWidth-1:0]  data_byte,
    input  logic                               start_frame,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [crc24fc_pkg::CrcWidth-1:0]   crc_value,
    output crc24fc_pkg::core_stat_t            stat
);

    logic                               stg_valid_reg;
    logic [crc24fc_pkg::DataWidth-1:0]  stg_data_reg;
    logic                               stg_start_reg;
    logic                               out_valid_reg;
    logic [crc24fc_pkg::CrcWidth-1:0]   crc_reg;
    logic [crc24fc_pkg::CrcWidth-1:0]   rem_reg;
    logic [crc24fc_pkg::CrcWidth-1:0]   rem_next;
    logic                               advance;
    logic                               accept;

    assign advance  = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stg_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // Bits enter least significant first; a set bit leaving the top folds in the taps.
    always_comb
    begin
        logic [crc24fc_pkg::CrcWidth-1:0] r;
        logic                             carry;
        r = stg_start_reg ? cfg.init_value : rem_reg;
        for (int i = 0; i < crc24fc_pkg::DataWidth; i++)
        begin
            carry = r[crc24fc_pkg::CrcWidth-1];
            r = {r[crc24fc_pkg::CrcWidth-2:0], stg_data_reg[i]};
            if (carry)
                r = r ^ cfg.poly_taps;
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= crc24fc_pkg::INIT_RESET;
        end
        else
        begin
            if (accept)
                stg_valid_reg <= 1'b1;
            else if (advance)
                stg_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                rem_reg       <= rem_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_data_reg  <= data_byte;
            stg_start_reg <= start_frame;
        end
        if (advance)
            crc_reg <= rem_next;
    end

    assign out_valid      = out_valid_reg;
    assign crc_value      = crc_reg;
    assign stat.stg_valid = stg_valid_reg;
    assign stat.advance   = advance;

endmodule

// File: sv/crc24_frame_checker.sv
// ----------------------------------------------------------------------------
// CRC-24 frame checker
// Running CRC-24 remainder over a byte stream, one result per byte.
// ----------------------------------------------------------------------------
// A byte accepted goes into the input register; when that stage advances, its
// remainder goes into the result register, from which its result item is taken.
// Throughput: one byte per cycle while results are taken; the eight bit steps are
// combinational between the input register and the result register, with the remainder fed back.
// Reset: remainder and init value go to 0x777777, taps to 0x800463, both
// stages empty.
module crc24_frame_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [crc24fc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [crc24fc_pkg::CfgDataW-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [crc24fc_pkg::DataWidth-1:0]  data_byte,
    input  logic                               start_frame,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [crc24fc_pkg::CrcWidth-1:0]   crc_value
);

    crc24fc_pkg::cfg_t        cfg;
    crc24fc_pkg::core_stat_t  stat;

    crc24fc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc24fc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .start_frame (start_frame),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .crc_value   (crc_value),
        .stat        (stat)
    );

    // Input is held off only when both the stage and the result register are full.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stat.stg_valid && out_valid && !out_ready))
        else $error("input stalled while a stage was free");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        stat.advance |=> out_valid)
        else $error("processed item did not reach the result register");

    a_taps_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == crc24fc_pkg::CFG_POLY_TAPS)
        |=> cfg.poly_taps == $past(cfg_data))
        else $error("tap pattern write was lost");

endmodule
